>>> hw/rtl/psd_pkg.sv
// shared types, widths, codes and threshold table of the pointer shake detector
package psd_pkg;

    localparam int COORD_BITS = 16;
    localparam int TIME_BITS  = 32;
    localparam int SENS_BITS  = 2;
    localparam int MS_BITS    = 16;
    localparam int CFG_BITS   = 16;
    localparam int CFG_IDX_BITS = 2;
    localparam int CNT_BITS   = 3;
    localparam int DIST_BITS  = 7;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic [TIME_BITS-1:0]         t_time;
    typedef logic [CNT_BITS-1:0]          t_cnt;
    typedef logic [1:0]                   t_dir;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_SENSITIVITY = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COOLDOWN    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDLE        = 2'd2;

    // sensitivity codes, anything else is medium
    localparam logic [SENS_BITS-1:0] SENS_LOW  = 2'd0;
    localparam logic [SENS_BITS-1:0] SENS_HIGH = 2'd2;

    localparam logic [SENS_BITS-1:0] SENS_RESET     = 2'd1;
    localparam logic [MS_BITS-1:0]   COOLDOWN_RESET = 16'd1500;
    localparam logic [MS_BITS-1:0]   IDLE_RESET     = 16'd300;

    // direction codes
    localparam t_dir DIR_NONE = 2'd0;
    localparam t_dir DIR_POS  = 2'd1;
    localparam t_dir DIR_NEG  = 2'd2;

    localparam t_cnt CNT_MAX = {CNT_BITS{1'b1}};

    typedef struct packed {
        logic [SENS_BITS-1:0] sensitivity;
        logic [MS_BITS-1:0]   cooldown_ms;
        logic [MS_BITS-1:0]   idle_ms;
    } t_cfg;

    typedef struct packed {
        logic [DIST_BITS-1:0] min_dist;
        t_cnt                 need;
    } t_thr;

    typedef struct packed {
        logic trigger_seen;
        logic anchor_valid;
        t_cnt reversal_count;
    } t_trk_status;

    function automatic t_thr sens_thresholds(input logic [SENS_BITS-1:0] sens);
        t_thr thr;
        unique case (sens)
            SENS_LOW: begin
                thr.min_dist = 7'd100;
                thr.need     = 3'd5;
            end
            SENS_HIGH: begin
                thr.min_dist = 7'd25;
                thr.need     = 3'd3;
            end
            default: begin
                thr.min_dist = 7'd50;
                thr.need     = 3'd4;
            end
        endcase
        return thr;
    endfunction

endpackage

>>> hw/rtl/psd_in_if.sv
// request channel carrying one pointer-move event
interface psd_in_if;
    logic                    valid;
    logic                    ready;
    psd_pkg::t_coord         pos_x;
    psd_pkg::t_coord         pos_y;
    psd_pkg::t_time          time_ms;

    modport source (output valid, output pos_x, output pos_y, output time_ms, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input time_ms, output ready);
endinterface

>>> hw/rtl/psd_out_if.sv
// result channel carrying the position of a detected shake
interface psd_out_if;
    logic                    valid;
    logic                    ready;
    psd_pkg::t_coord         shake_x;
    psd_pkg::t_coord         shake_y;

    modport source (output valid, output shake_x, output shake_y, input ready);
    modport sink   (input valid, input shake_x, input shake_y, output ready);
endinterface

>>> hw/rtl/psd_cfg_regs.sv
// configuration register bank of the shake detector
module psd_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [psd_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [psd_pkg::CFG_BITS-1:0]        i_cfg_data,
    output psd_pkg::t_cfg                       o_cfg
);

    psd_pkg::t_cfg r_cfg;
    psd_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                psd_pkg::CFG_SENSITIVITY:
                    n_cfg.sensitivity = i_cfg_data[psd_pkg::SENS_BITS-1:0];
                psd_pkg::CFG_COOLDOWN:
                    n_cfg.cooldown_ms = i_cfg_data[psd_pkg::MS_BITS-1:0];
                psd_pkg::CFG_IDLE:
                    n_cfg.idle_ms = i_cfg_data[psd_pkg::MS_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sensitivity <= psd_pkg::SENS_RESET;
            r_cfg.cooldown_ms <= psd_pkg::COOLDOWN_RESET;
            r_cfg.idle_ms     <= psd_pkg::IDLE_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> hw/rtl/psd_tracker.sv
// gesture tracking state and per-event update logic
module psd_tracker (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  psd_pkg::t_cfg          i_cfg,
    input  logic                   i_commit,
    input  psd_pkg::t_coord        i_x,
    input  psd_pkg::t_time         i_time,
    output logic                   o_hit,
    output psd_pkg::t_trk_status   o_status
);

    localparam int DW = psd_pkg::COORD_BITS + 1;

    psd_pkg::t_coord r_anchor_pos, n_anchor_pos;
    logic            r_anchor_vld, n_anchor_vld;
    psd_pkg::t_dir   r_last_dir,   n_last_dir;
    psd_pkg::t_cnt   r_cnt,        n_cnt;
    logic            r_trig_seen,  n_trig_seen;
    psd_pkg::t_time  r_trig_time,  n_trig_time;
    psd_pkg::t_time  r_evt_time,   n_evt_time;

    psd_pkg::t_time  w_since_trig;
    psd_pkg::t_time  w_since_evt;
    logic            w_cool;
    logic            w_idle;
    psd_pkg::t_thr   w_thr;
    psd_pkg::t_coord w_base;
    logic signed [DW-1:0] w_dx;
    logic [DW-1:0]   w_adx;
    psd_pkg::t_dir   w_dir;
    logic            w_hit;

    assign w_since_trig = i_time - r_trig_time;
    assign w_since_evt  = i_time - r_evt_time;
    assign w_cool = r_trig_seen &&
        (w_since_trig < {{(psd_pkg::TIME_BITS-psd_pkg::MS_BITS){1'b0}}, i_cfg.cooldown_ms});
    assign w_idle =
        (w_since_evt > {{(psd_pkg::TIME_BITS-psd_pkg::MS_BITS){1'b0}}, i_cfg.idle_ms});
    assign w_thr  = psd_pkg::sens_thresholds(i_cfg.sensitivity);

    // after an idle gap the anchor restarts at the current x
    assign w_base = w_idle ? i_x : r_anchor_pos;
    assign w_dx   = {i_x[psd_pkg::COORD_BITS-1], i_x}
                  - {w_base[psd_pkg::COORD_BITS-1], w_base};
    assign w_adx  = w_dx[DW-1] ? DW'(-w_dx) : DW'(w_dx);
    assign w_dir  = w_dx[DW-1] ? psd_pkg::DIR_NEG : psd_pkg::DIR_POS;

    always_comb begin
        n_anchor_pos = r_anchor_pos;
        n_anchor_vld = r_anchor_vld;
        n_last_dir   = r_last_dir;
        n_cnt        = r_cnt;
        n_trig_seen  = r_trig_seen;
        n_trig_time  = r_trig_time;
        n_evt_time   = r_evt_time;
        w_hit        = 1'b0;
        if (w_cool) begin
            n_anchor_vld = 1'b0;
            n_cnt        = '0;
        end else begin
            n_evt_time = i_time;
            if (w_idle) begin
                n_anchor_pos = i_x;
                n_anchor_vld = 1'b1;
                n_cnt        = '0;
                n_last_dir   = psd_pkg::DIR_NONE;
            end
            if (!r_anchor_vld && !w_idle) begin
                n_anchor_pos = i_x;
                n_anchor_vld = 1'b1;
            end else if (w_adx > {{(DW-psd_pkg::DIST_BITS){1'b0}}, w_thr.min_dist}) begin
                if (n_last_dir == psd_pkg::DIR_NONE) begin
                    n_cnt = psd_pkg::t_cnt'(1);
                end else if (w_dir != n_last_dir && n_cnt != psd_pkg::CNT_MAX) begin
                    n_cnt = n_cnt + psd_pkg::t_cnt'(1);
                end
                n_last_dir   = w_dir;
                n_anchor_pos = i_x;
                if (n_cnt >= w_thr.need) begin
                    w_hit        = 1'b1;
                    n_trig_time  = i_time;
                    n_trig_seen  = 1'b1;
                    n_cnt        = '0;
                    n_last_dir   = psd_pkg::DIR_NONE;
                    n_anchor_vld = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_anchor_vld <= 1'b0;
            r_last_dir   <= psd_pkg::DIR_NONE;
            r_cnt        <= '0;
            r_trig_seen  <= 1'b0;
            r_evt_time   <= '0;
        end else if (i_commit) begin
            r_anchor_vld <= n_anchor_vld;
            r_last_dir   <= n_last_dir;
            r_cnt        <= n_cnt;
            r_trig_seen  <= n_trig_seen;
            r_evt_time   <= n_evt_time;
        end
    end

    // guarded by the valid flags, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_commit) begin
            r_anchor_pos <= n_anchor_pos;
            r_trig_time  <= n_trig_time;
        end
    end

    assign o_hit = w_hit;
    assign o_status.trigger_seen   = r_trig_seen;
    assign o_status.anchor_valid   = r_anchor_vld;
    assign o_status.reversal_count = r_cnt;

endmodule

>>> hw/rtl/pointer_shake_detector_core.sv
// top level of the pointer shake detector
//
// takes one pointer-move request per clock cycle and emits the position of
// the event that completes a horizontal shake (zero or one result per
// request). a request is captured in an input register, the tracking state
// is updated by one pass of compare and add logic when the request leaves
// that register, and a detection is placed in the output register at the
// same edge, where it waits until the consumer takes it. the sustained rate
// is one request per cycle, set by the single state update stage; it drops
// only while a result waits in the output register and the consumer holds
// ready low. configuration is written through a plain write port; the user
// must write it only while no request is in flight, the block itself does
// not enforce this. sensitivity picks the distance and reversal thresholds,
// cooldown_ms holds tracking cleared after a detection and idle_ms restarts
// tracking after a quiet gap. timestamps compare modulo 2^32.
module pointer_shake_detector_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    psd_in_if.sink                           i_in,
    psd_out_if.source                        o_out,
    input  logic                             i_cfg_we,
    input  logic [psd_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [psd_pkg::CFG_BITS-1:0]     i_cfg_data
);

    psd_pkg::t_cfg        w_cfg;
    psd_pkg::t_trk_status w_status;

    // input register
    logic            r_in_vld;
    psd_pkg::t_coord r_in_x;
    psd_pkg::t_coord r_in_y;
    psd_pkg::t_time  r_in_time;

    // output register
    logic            r_out_vld;
    psd_pkg::t_coord r_out_x;
    psd_pkg::t_coord r_out_y;

    logic w_adv;
    logic w_take;
    logic w_hit;

    // the held request moves on once the output slot is free or being drained
    assign w_adv  = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || w_adv;
    assign w_take = i_in.valid && i_in.ready;

    psd_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    psd_tracker u_trk (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_commit (w_adv),
        .i_x      (r_in_x),
        .i_time   (r_in_time),
        .o_hit    (w_hit),
        .o_status (w_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_take) begin
            r_in_vld <= 1'b1;
        end else if (w_adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_x    <= i_in.pos_x;
            r_in_y    <= i_in.pos_y;
            r_in_time <= i_in.time_ms;
        end
    end

    // a detection loads the result; otherwise a taken result empties the slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv && w_hit) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_hit) begin
            r_out_x <= r_in_x;
            r_out_y <= r_in_y;
        end
    end

    assign o_out.valid   = r_out_vld;
    assign o_out.shake_x = r_out_x;
    assign o_out.shake_y = r_out_y;

`ifndef SYNTHESIS
    // a new request is only taken when the held one leaves in the same cycle
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && r_in_vld) |-> w_adv)
        else $error("input register overwritten");

    // a detection shows up as a result and arms the cooldown
    a_hit_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_hit) |=> (o_out.valid && w_status.trigger_seen && !w_status.anchor_valid
                              && w_status.reversal_count == '0))
        else $error("detection not delivered");

    // a pending result is never replaced before it is taken
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> (o_out.valid && $stable(o_out.shake_x)
                                           && $stable(o_out.shake_y)))
        else $error("pending result lost");
`endif

endmodule

>>> bench/psd_checker.sv
// checker for the pointer shake detector: tracks gestures alongside the block and compares results
module psd_checker
    import psd_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    psd_in_if                       i_in_ch,
    psd_out_if                      i_out_ch,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [CFG_BITS-1:0]     i_cfg_data,
    output int                      o_pending,
    output int                      o_errors
);

    typedef struct packed {
        t_coord shake_x;
        t_coord shake_y;
    } t_shake_pos;

    // shake positions still owed by the block, oldest first
    t_shake_pos shake_q[$];

    // configuration copy
    logic [SENS_BITS-1:0] sens;
    logic [MS_BITS-1:0]   cooldown;
    logic [MS_BITS-1:0]   idle;

    // gesture tracking copy
    t_coord anchor_x;
    logic   anchor_ok;
    t_dir   last_dir;
    t_cnt   rev_cnt;
    logic   trig_seen;
    t_time  trig_time;
    t_time  evt_time;

    int err_cnt;

    task automatic predict_shake(input t_coord x, input t_coord y, input t_time now);
        t_time since_trig;
        t_time since_evt;
        int    thr_dist;
        t_cnt  need;
        int    dx;
        t_dir  dir;
        since_trig = now - trig_time;
        since_evt  = now - evt_time;
        // cooldown: drop the anchor and the count, keep direction and event time
        if (trig_seen && since_trig < t_time'(cooldown)) begin
            anchor_ok = 1'b0;
            rev_cnt   = '0;
            return;
        end
        // quiet gap: restart from the current position
        if (since_evt > t_time'(idle)) begin
            anchor_x  = x;
            anchor_ok = 1'b1;
            rev_cnt   = '0;
            last_dir  = DIR_NONE;
        end
        evt_time = now;
        if (!anchor_ok) begin
            anchor_x  = x;
            anchor_ok = 1'b1;
            return;
        end
        case (sens)
            SENS_LOW: begin
                thr_dist = 100;
                need     = 3'd5;
            end
            SENS_HIGH: begin
                thr_dist = 25;
                need     = 3'd3;
            end
            default: begin
                thr_dist = 50;
                need     = 3'd4;
            end
        endcase
        dx = int'(x) - int'(anchor_x);
        if ((dx < 0 ? -dx : dx) <= thr_dist)
            return;
        dir = (dx > 0) ? DIR_POS : DIR_NEG;
        if (last_dir == DIR_NONE)
            rev_cnt = 3'd1;
        else if (dir != last_dir && rev_cnt != CNT_MAX)
            rev_cnt = rev_cnt + 3'd1;
        last_dir = dir;
        anchor_x = x;
        if (rev_cnt >= need) begin
            trig_time = now;
            trig_seen = 1'b1;
            rev_cnt   = '0;
            last_dir  = DIR_NONE;
            anchor_ok = 1'b0;
            shake_q.push_back('{shake_x: x, shake_y: y});
        end
    endtask

    always @(posedge i_clk) begin
        t_shake_pos want;
        if (!i_rst_n) begin
            sens      = SENS_RESET;
            cooldown  = COOLDOWN_RESET;
            idle      = IDLE_RESET;
            anchor_x  = '0;
            anchor_ok = 1'b0;
            last_dir  = DIR_NONE;
            rev_cnt   = '0;
            trig_seen = 1'b0;
            trig_time = '0;
            evt_time  = '0;
            err_cnt   = 0;
            shake_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SENSITIVITY: sens     = i_cfg_data[SENS_BITS-1:0];
                    CFG_COOLDOWN:    cooldown = i_cfg_data[MS_BITS-1:0];
                    CFG_IDLE:        idle     = i_cfg_data[MS_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_in_ch.valid && i_in_ch.ready)
                predict_shake(i_in_ch.pos_x, i_in_ch.pos_y, i_in_ch.time_ms);
            if (i_out_ch.valid && i_out_ch.ready) begin
                if (shake_q.size() == 0) begin
                    if (err_cnt < 10)
                        $display("unexpected shake result: x %0d y %0d",
                                 i_out_ch.shake_x, i_out_ch.shake_y);
                    err_cnt++;
                end else begin
                    want = shake_q.pop_front();
                    if (i_out_ch.shake_x !== want.shake_x ||
                        i_out_ch.shake_y !== want.shake_y) begin
                        if (err_cnt < 10)
                            $display("shake mismatch: expected x %0d y %0d, got x %0d y %0d",
                                     want.shake_x, want.shake_y,
                                     i_out_ch.shake_x, i_out_ch.shake_y);
                        err_cnt++;
                    end
                end
            end
        end
        o_pending <= shake_q.size();
        o_errors  <= err_cnt;
    end

endmodule

>>> bench/tb_top.sv
// top of the pointer shake detector bench: clock, reset, event stimulus, config phases and verdict
module tb_top
    import psd_pkg::*;
;

    // medium sensitivity has two codes, both exercised
    localparam logic [SENS_BITS-1:0] SENS_MEDIUM     = 2'd1;
    localparam logic [SENS_BITS-1:0] SENS_ALT_MEDIUM = 2'd3;

    // a result passes the input and output registers; settle margin on top
    localparam int DRAIN = 8;
    // far above the slowest legal run including all stalls
    localparam int CYCLE_LIMIT = 400000;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx;
    logic [CFG_BITS-1:0]     i_cfg_data;

    psd_in_if  in_ch();
    psd_out_if out_ch();

    int pending;
    int errors;
    int cycle_cnt;
    int events_sent;

    // stimulus-side view of the pointer
    t_time cur_t;
    int    cur_x;
    // when set, neither side inserts idle cycles
    logic  no_idle;

    pointer_shake_detector_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    psd_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_ch    (in_ch),
        .i_out_ch   (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_pending  (pending),
        .o_errors   (errors)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // watchdog, ends a hung run
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("FAIL");
        $finish;
    end

    // result consumer stalls about one cycle in five unless no_idle is set
    always @(posedge i_clk) begin
        out_ch.ready <= no_idle || ($urandom_range(0, 99) >= 20);
    end

    // one pointer-move request, with random idle cycles ahead of it
    task automatic send_event(input int x, input int y, input t_time t);
        if (!no_idle) begin
            while ($urandom_range(0, 99) < 20) begin
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        in_ch.valid   <= 1'b1;
        in_ch.pos_x   <= t_coord'(x);
        in_ch.pos_y   <= t_coord'(y);
        in_ch.time_ms <= t;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        events_sent++;
    endtask

    // stop sending and let every owed result come out
    task automatic hold_off();
        in_ch.valid <= 1'b0;
        repeat (DRAIN) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    // write all three registers on back-to-back cycles, enable held high throughout
    task automatic write_config(input logic [SENS_BITS-1:0] sens,
                                input logic [MS_BITS-1:0] cool,
                                input logic [MS_BITS-1:0] idle);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_SENSITIVITY;
        i_cfg_data <= CFG_BITS'(sens);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_COOLDOWN;
        i_cfg_data <= cool;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_IDLE;
        i_cfg_data <= idle;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // one setting, then random traffic: mostly well-formed shakes, some noise and quiet drift
    task automatic run_phase(input logic [SENS_BITS-1:0] sens,
                             input logic [MS_BITS-1:0] cool,
                             input logic [MS_BITS-1:0] idle,
                             input int n_items);
        int    phase_end;
        int    kind;
        int    n_ev;
        int    thr_dist;
        int    step;
        int    dir;
        int    nx;
        int    r;
        t_time dt;
        hold_off();
        write_config(sens, cool, idle);
        case (sens)
            SENS_LOW:  thr_dist = 100;
            SENS_HIGH: thr_dist = 25;
            default:   thr_dist = 50;
        endcase
        phase_end = events_sent + n_items;
        while (events_sent < phase_end) begin
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                // shake: jump past any cooldown, then swing back and forth
                cur_t = cur_t + cool + 1 + $urandom_range(0, 500);
                cur_x = $urandom_range(0, 40000) - 20000;
                dir   = ($urandom_range(0, 1) != 0) ? 1 : -1;
                n_ev  = $urandom_range(6, 9);
                send_event(cur_x, $urandom, cur_t);
                for (int k = 1; k < n_ev; k++) begin
                    r = $urandom_range(0, 99);
                    // small move up to and including the threshold, else past it
                    if (r < 8)
                        step = $urandom_range(0, thr_dist);
                    else if ($urandom_range(0, 3) == 0)
                        step = thr_dist + 1;
                    else
                        step = thr_dist + 1 + $urandom_range(0, 150);
                    // a few moves keep the old direction
                    if (r >= 16)
                        dir = -dir;
                    nx = cur_x + dir * step;
                    if (nx > 32767 || nx < -32768) begin
                        dir = -dir;
                        nx  = cur_x + dir * step;
                    end
                    cur_x = nx;
                    // now and then a gap just over the idle time breaks the gesture
                    if (r >= 16 && r < 20)
                        dt = idle + 1 + $urandom_range(0, 50);
                    else
                        dt = $urandom_range(0, int'(idle));
                    cur_t = cur_t + dt;
                    send_event(cur_x, $urandom, cur_t);
                end
            end else if (kind < 85) begin
                // noise: full-range positions, timestamps that may jump anywhere
                n_ev = $urandom_range(1, 4);
                for (int k = 0; k < n_ev; k++) begin
                    if ($urandom_range(0, 1) != 0)
                        cur_t = $urandom;
                    else
                        cur_t = cur_t + $urandom_range(0, 3000);
                    send_event($urandom, $urandom, cur_t);
                end
            end else begin
                // quiet drift around the last position
                for (int k = 0; k < 3; k++) begin
                    nx = cur_x + $urandom_range(0, 2 * thr_dist) - thr_dist;
                    if (nx > 32767)
                        nx = 32767;
                    if (nx < -32768)
                        nx = -32768;
                    cur_t = cur_t + $urandom_range(0, 2 * int'(idle) + 2);
                    send_event(nx, $urandom, cur_t);
                end
            end
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.pos_x   <= '0;
        in_ch.pos_y   <= '0;
        in_ch.time_ms <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_SENSITIVITY;
        i_cfg_data    <= '0;
        no_idle     = 1'b0;
        events_sent = 0;
        cur_t       = '0;
        cur_x       = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at the reset settings: medium, cooldown 1500, idle 300
        // first event only sets the anchor, event time zero after reset counts as normal
        send_event(0, 0, 32'd0);
        // move of exactly the threshold changes nothing
        send_event(50, 1, 32'd10);
        // just past the threshold starts the count
        send_event(51, -1, 32'd20);
        // same direction keeps the count
        send_event(200, 2, 32'd30);
        // three reversals complete the shake
        send_event(100, -2, 32'd40);
        send_event(200, 3, 32'd50);
        send_event(100, 12345, 32'd60);
        // inside the cooldown
        send_event(-32768, 4, 32'd100);
        // past cooldown and idle, coordinate extremes back and forth
        send_event(32767, -32768, 32'd2000);
        send_event(-32768, 32767, 32'd2010);
        send_event(32767, -32768, 32'd2020);
        send_event(-32768, 32767, 32'd2030);
        send_event(32767, -32768, 32'd2040);
        // shake across the timestamp wrap
        send_event(0, 5, 32'hFFFF_FF00);
        send_event(60, 6, 32'hFFFF_FFF0);
        send_event(0, 7, 32'h0000_0010);
        send_event(60, 8, 32'h0000_0020);
        send_event(0, -9, 32'h0000_0030);
        // idle restart one over the limit, then a gap of exactly the limit
        send_event(1000, 10, 32'd2000);
        send_event(2000, 11, 32'd2301);
        send_event(2100, 12, 32'd2601);
        cur_t = 32'd2601;
        cur_x = 2100;

        // random part over several settings, extremes included
        run_phase(SENS_LOW,        16'd1500,  16'd300,   141);
        run_phase(SENS_HIGH,       16'd1500,  16'd300,   141);
        run_phase(SENS_ALT_MEDIUM, 16'd200,   16'd100,   141);
        run_phase(SENS_MEDIUM,     16'd0,     16'd0,     141);
        // a long stretch where neither side idles
        no_idle = 1'b1;
        run_phase(SENS_LOW,        16'hFFFF,  16'hFFFF,  141);
        no_idle = 1'b0;
        run_phase(SENS_HIGH,       16'd0,     16'hFFFF,  141);
        run_phase(SENS_ALT_MEDIUM, 16'hFFFF,  16'd0,     141);
        run_phase(SENS_MEDIUM,     16'd1000,  16'd500,   141);

        hold_off();
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
